### design/pbfs_pkg.sv
package pbfs_pkg;

    // Field and state widths
    localparam int PCT_W   = 7;
    localparam int MS_W    = 16;
    localparam int TIME_W  = 48;
    localparam int LEN_W   = 26;
    localparam int CMD_W   = 2;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;

    // Product of a level difference and an elapsed time below the ramp length
    localparam int PROD_W  = PCT_W + LEN_W;
    localparam int CNT_W   = $clog2(PCT_W);

    localparam logic [PCT_W-1:0] MAX_PCT = PCT_W'(100);

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_WAKE_MS  = IDX_W'(0);
    localparam logic [IDX_W-1:0] CFG_SLEEP_MS = IDX_W'(1);
    localparam logic [IDX_W-1:0] CFG_INIT_PCT = IDX_W'(2);

    // Display power commands
    localparam logic [CMD_W-1:0] CMD_NONE = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_ON   = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_OFF  = CMD_W'(2);

    // Input action codes
    localparam logic ACT_STEP    = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    // Saturate a percent to 100
    function automatic logic [PCT_W-1:0] sat_pct(input logic [PCT_W-1:0] v);
        return (v > MAX_PCT) ? MAX_PCT : v;
    endfunction

    // Milliseconds to microseconds: ms*1000 = ms*1024 - ms*16 - ms*8
    function automatic logic [LEN_W-1:0] ms_to_us(input logic [MS_W-1:0] ms);
        logic [LEN_W-1:0] w;
        w = LEN_W'(ms);
        return (w << 10) - (w << 4) - (w << 3);
    endfunction

endpackage

### design/pbfs_muldiv.sv
module pbfs_muldiv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pbfs_pkg::PCT_W-1:0]    i_diff,
    input  logic [pbfs_pkg::LEN_W-1:0]    i_elap,
    input  logic [pbfs_pkg::LEN_W-1:0]    i_len,
    output logic                          o_done,
    output logic [pbfs_pkg::PCT_W-1:0]    o_quot
);
    import pbfs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV
    } t_md_state;

    t_md_state           r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [PCT_W-1:0]    r_diff;
    logic [LEN_W-1:0]    r_elap;
    logic [PROD_W-1:0]   r_acc;
    logic [PROD_W-1:0]   r_div;
    logic [PCT_W-1:0]    r_quot;
    logic                r_done;

    logic                w_sub;
    logic [PROD_W-1:0]   w_opa;
    logic [PROD_W-1:0]   w_opb;
    logic [PROD_W:0]     w_sum;

    // Shared adder: shift-add for the product, compare-subtract for the quotient
    always_comb begin
        w_sub = (r_state == S_DIV);
        if (w_sub) begin
            w_opa = r_acc;
            w_opb = r_div;
        end else begin
            w_opa = {r_acc[PROD_W-2:0], 1'b0};
            w_opb = r_diff[r_cnt] ? PROD_W'(r_elap) : '0;
        end
        w_sum = {1'b0, w_opa}
              + (w_sub ? {1'b1, ~w_opb} : {1'b0, w_opb})
              + (PROD_W+1)'(w_sub);
    end

    // Sequence multiply then divide, one bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_acc   <= '0;
                        r_diff  <= i_diff;
                        r_elap  <= i_elap;
                        r_div   <= PROD_W'(i_len) << (PCT_W - 1);
                        r_quot  <= '0;
                        r_cnt   <= CNT_W'(PCT_W - 1);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_acc <= w_sum[PROD_W-1:0];
                    if (r_cnt == '0) begin
                        r_cnt   <= CNT_W'(PCT_W - 1);
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_DIV: begin
                    // Keep the difference only when it did not borrow
                    if (!w_sum[PROD_W]) begin
                        r_acc <= w_sum[PROD_W-1:0];
                    end
                    r_quot <= {r_quot[PCT_W-2:0], ~w_sum[PROD_W]};
                    r_div  <= r_div >> 1;
                    if (r_cnt == '0) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### design/panel_brightness_fade_sequencer_unit.sv
// Channel   Handshake           Payload
// --------  ------------------  ---------------------------------------------------
// in        i_valid / o_ready   i_action, i_now_us, i_panel_on_req, i_target_level
// out       o_valid / i_ready   o_level_write, o_level_value, o_display_cmd,
//                               o_fade_busy
// cfg       i_cfg_we            i_cfg_idx, i_cfg_wdata (no wait, no read-back)
//
// A request, or a step with no ramp in flight, finishes in the accept cycle.
// A step that ends the ramp goes through ST_ELAP (elapsed time) and ST_DONE;
// a mid-ramp step goes through ST_ELAP, ST_CALC (multiply then divide on the
// shared adder) and the ST_DONE hand-off. One request is worked at a time.
// Reset is synchronous, active low; it reloads the settings and fade state.
// A stalled output holds the result; o_ready stays low until it drains.
module panel_brightness_fade_sequencer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_action,
    input  logic [pbfs_pkg::TIME_W-1:0]   i_now_us,
    input  logic                          i_panel_on_req,
    input  logic [pbfs_pkg::PCT_W-1:0]    i_target_level,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_level_write,
    output logic [pbfs_pkg::PCT_W-1:0]    o_level_value,
    output logic [pbfs_pkg::CMD_W-1:0]    o_display_cmd,
    output logic                          o_fade_busy,
    input  logic                          i_cfg_we,
    input  logic [pbfs_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [pbfs_pkg::CFG_W-1:0]    i_cfg_wdata
);
    import pbfs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ELAP,
        ST_CALC,
        ST_DONE
    } t_state;

    t_state              r_state;
    logic [MS_W-1:0]     r_wake_ms;
    logic [MS_W-1:0]     r_sleep_ms;
    logic [PCT_W-1:0]    r_cur;
    logic [PCT_W-1:0]    r_start;
    logic [PCT_W-1:0]    r_end;
    logic [TIME_W-1:0]   r_t0;
    logic [LEN_W-1:0]    r_len;
    logic                r_active;
    logic                r_off_pend;
    logic                r_prev_pwr;
    logic [TIME_W-1:0]   r_now;
    logic [CMD_W-1:0]    r_cmd;
    logic [LEN_W-1:0]    r_elap;
    logic                r_md_start;
    logic                r_out_valid;
    logic                r_out_write;
    logic [PCT_W-1:0]    r_out_level;
    logic [CMD_W-1:0]    r_out_cmd;
    logic                r_out_busy;

    logic                w_out_free;
    logic                w_accept;
    logic [PCT_W-1:0]    w_req_tgt_in;
    logic [PCT_W-1:0]    w_req_tgt;
    logic [MS_W-1:0]     w_req_ms;
    logic                w_req_off;
    logic [CMD_W-1:0]    w_req_cmd;
    logic                w_req_snap;
    logic                w_req_write;
    logic [TIME_W-1:0]   w_elap_full;
    logic                w_late;
    logic                w_ended;
    logic                w_up;
    logic [PCT_W-1:0]    w_diff;
    logic                w_md_done;
    logic [PCT_W-1:0]    w_md_quot;
    logic [PCT_W-1:0]    w_ramp_lvl;

    assign w_out_free = !r_out_valid || i_ready;
    assign o_ready    = (r_state == ST_IDLE) && w_out_free;
    assign w_accept   = i_valid && o_ready;

    // Decode a power/brightness request against the held state
    always_comb begin
        w_req_tgt_in = sat_pct(i_target_level);
        w_req_off    = 1'b0;
        w_req_cmd    = CMD_NONE;
        if (i_panel_on_req && !r_prev_pwr) begin
            w_req_tgt = w_req_tgt_in;
            w_req_ms  = r_wake_ms;
            w_req_cmd = CMD_ON;
        end else if (!i_panel_on_req && r_prev_pwr) begin
            w_req_tgt = '0;
            w_req_ms  = r_sleep_ms;
            w_req_off = 1'b1;
        end else begin
            w_req_tgt = w_req_tgt_in;
            w_req_ms  = (w_req_tgt_in > r_cur) ? r_wake_ms : r_sleep_ms;
        end
        w_req_snap  = (w_req_ms == '0) || (w_req_tgt == r_cur);
        w_req_write = w_req_snap && (w_req_tgt != r_cur);
        if (w_req_snap && w_req_off) begin
            w_req_cmd = CMD_OFF;
        end
    end

    // Elapsed time since ramp start, floored at zero
    assign w_late      = (r_now >= r_t0);
    assign w_elap_full = r_now - r_t0;
    assign w_ended     = w_late && ((|w_elap_full[TIME_W-1:LEN_W])
                                    || (w_elap_full[LEN_W-1:0] >= r_len));

    // Ramp direction and span
    assign w_up   = (r_end >= r_start);
    assign w_diff = w_up ? (r_end - r_start) : (r_start - r_end);

    assign w_ramp_lvl = sat_pct(w_up ? (r_start + w_md_quot) : (r_start - w_md_quot));

    pbfs_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_md_start),
        .i_diff  (w_diff),
        .i_elap  (r_elap),
        .i_len   (r_len),
        .o_done  (w_md_done),
        .o_quot  (w_md_quot)
    );

    // Sequencer, fade state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wake_ms   <= MS_W'(250);
            r_sleep_ms  <= MS_W'(1000);
            r_cur       <= PCT_W'(70);
            r_start     <= '0;
            r_end       <= '0;
            r_t0        <= '0;
            r_len       <= '0;
            r_active    <= 1'b0;
            r_off_pend  <= 1'b0;
            r_prev_pwr  <= 1'b1;
            r_md_start  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_md_start <= 1'b0;

            // Drop the output once taken
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            // Apply configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WAKE_MS:  r_wake_ms  <= i_cfg_wdata[MS_W-1:0];
                    CFG_SLEEP_MS: r_sleep_ms <= i_cfg_wdata[MS_W-1:0];
                    CFG_INIT_PCT: begin
                        r_cur <= sat_pct(i_cfg_wdata[PCT_W-1:0]);
                    end
                    default: ;
                endcase
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (i_action == ACT_REQUEST) begin
                            // Snap or start a ramp, report at once
                            r_prev_pwr  <= i_panel_on_req;
                            r_out_valid <= 1'b1;
                            r_out_cmd   <= w_req_cmd;
                            if (w_req_snap) begin
                                r_cur       <= w_req_tgt;
                                r_active    <= 1'b0;
                                r_off_pend  <= 1'b0;
                                r_out_write <= w_req_write;
                                r_out_level <= w_req_tgt;
                                r_out_busy  <= 1'b0;
                            end else begin
                                r_start     <= r_cur;
                                r_end       <= w_req_tgt;
                                r_t0        <= i_now_us;
                                r_len       <= ms_to_us(w_req_ms);
                                r_off_pend  <= w_req_off;
                                r_active    <= 1'b1;
                                r_out_write <= 1'b0;
                                r_out_level <= r_cur;
                                r_out_busy  <= 1'b1;
                            end
                        end else if (!r_active) begin
                            // Idle tick: report the held level
                            r_out_valid <= 1'b1;
                            r_out_write <= 1'b0;
                            r_out_level <= r_cur;
                            r_out_cmd   <= CMD_NONE;
                            r_out_busy  <= 1'b0;
                        end else begin
                            r_now   <= i_now_us;
                            r_state <= ST_ELAP;
                        end
                    end
                end
                ST_ELAP: begin
                    if (w_ended) begin
                        // Finish the ramp, release display-off if pending
                        r_cur      <= r_end;
                        r_active   <= 1'b0;
                        r_off_pend <= 1'b0;
                        r_cmd      <= r_off_pend ? CMD_OFF : CMD_NONE;
                        r_state    <= ST_DONE;
                    end else begin
                        r_elap     <= w_late ? w_elap_full[LEN_W-1:0] : '0;
                        r_md_start <= 1'b1;
                        r_state    <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    if (w_md_done) begin
                        r_cur   <= w_ramp_lvl;
                        r_cmd   <= CMD_NONE;
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // Hold until the output register is free
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_write <= 1'b1;
                        r_out_level <= r_cur;
                        r_out_cmd   <= r_cmd;
                        r_out_busy  <= r_active;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_level_write = r_out_write;
    assign o_level_value = r_out_level;
    assign o_display_cmd = r_out_cmd;
    assign o_fade_busy   = r_out_busy;

endmodule
